// File: sv/ble_pkg.sv
package ble_pkg;

  localparam int VAL_W     = 32;
  localparam int POS_W     = 6;
  localparam int REQ_W     = 3;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD  = 3'd0,
    REQ_INS_TAIL  = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_DEL_HEAD  = 3'd3,
    REQ_DEL_TAIL  = 3'd4,
    REQ_READ      = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CHK,
    S_UP_MOVE,
    S_DN_CHK,
    S_DN_MOVE,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_POS,
    RA_BELOW,
    RA_ABOVE
  } raddr_sel_t;

  typedef enum logic {
    WA_CUR,
    WA_TARGET
  } waddr_sel_t;

  typedef struct packed {
    logic       latch;
    logic       cur_held;
    logic       cur_zero;
    logic       cur_dec;
    logic       cur_inc;
    logic       rd_en;
    raddr_sel_t rd_sel;
    logic       wr_en;
    waddr_sel_t wr_sel;
    logic       held_inc;
    logic       held_dec;
    logic       held_clr;
    logic       st_set;
    status_t    st_code;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    req_t op;
    logic full;
    logic empty;
    logic pos_bad;
    logic at_target;
    logic at_last;
    logic res_valid;
  } sts_t;

endpackage

// File: sv/ble_dpath.sv
module ble_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ble_pkg::REQ_W-1:0]     req_in,
  input  logic signed [ble_pkg::VAL_W-1:0] value_in,
  input  logic [ble_pkg::POS_W-1:0]     pos_in,
  input  ble_pkg::cmd_t                 cmd,
  output ble_pkg::sts_t                 sts,
  input  logic                          out_ready,
  output logic                          res_valid,
  output logic [ble_pkg::ST_W-1:0]      status,
  output logic signed [ble_pkg::VAL_W-1:0] read_value,
  output logic [ble_pkg::CNT_OUT_W-1:0] entry_count
);
  import ble_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  req_t             op_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;
  logic [CW-1:0]    target;
  logic [CW-1:0]    target_next;
  logic [CW-1:0]    cur;
  logic [CW-1:0]    held;
  status_t          st;

  logic [CW-1:0]    cur_m1;
  logic [CW-1:0]    cur_p1;
  logic [CW-1:0]    waddr_full;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] wdata;

  assign cur_m1 = CW'(cur - 1'b1);
  assign cur_p1 = CW'(cur + 1'b1);

  // where a new entry lands: head, after the given index, or at the tail
  always_comb begin
    case (req_t'(req_in))
      REQ_INS_HEAD:  target_next = '0;
      REQ_INS_AFTER: target_next = CW'(CW'(pos_in) + 1'b1);
      default:       target_next = held;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= req_t'(req_in);
      val_q  <= value_in;
      pos_q  <= pos_in;
      target <= target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_held) begin
      cur <= held;
    end else if (cmd.cur_zero) begin
      cur <= '0;
    end else if (cmd.cur_dec) begin
      cur <= cur_m1;
    end else if (cmd.cur_inc) begin
      cur <= cur_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.held_clr) begin
      held <= '0;
    end else if (cmd.held_inc) begin
      held <= CW'(held + 1'b1);
    end else if (cmd.held_dec) begin
      held <= CW'(held - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_set) begin
      st <= cmd.st_code;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_BELOW: raddr = cur_m1[AW-1:0];
      RA_ABOVE: raddr = cur_p1[AW-1:0];
      default:  raddr = AW'(pos_q);
    endcase
  end

  assign waddr_full = (cmd.wr_sel == WA_TARGET) ? target : cur;
  assign waddr      = waddr_full[AW-1:0];
  assign wdata      = (cmd.wr_sel == WA_TARGET) ? val_q : rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status      <= st;
      read_value  <= (op_q == REQ_READ && st == ST_OK) ? rdata : '0;
      entry_count <= CNT_OUT_W'(held);
    end
  end

  assign sts.op        = op_q;
  assign sts.full      = (held == CW'(CAPACITY));
  assign sts.empty     = (held == '0);
  assign sts.pos_bad   = (MW'(pos_q) >= MW'(held));
  assign sts.at_target = (cur == target);
  assign sts.at_last   = (cur_p1 == held);
  assign sts.res_valid = res_valid;

  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_waddr_range : assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (waddr_full < CW'(CAPACITY)))
    else $error("store write outside capacity");

  a_res_slot : assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!res_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// File: sv/ble_ctrl.sv
module ble_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  ble_pkg::sts_t sts,
  output ble_pkg::cmd_t cmd
);
  import ble_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op) inside
          REQ_INS_HEAD, REQ_INS_TAIL: begin
            state_next = sts.full ? S_DONE : S_UP_CHK;
          end
          REQ_INS_AFTER: begin
            state_next = (sts.pos_bad || sts.full) ? S_DONE : S_UP_CHK;
          end
          REQ_DEL_HEAD: begin
            state_next = sts.empty ? S_DONE : S_DN_CHK;
          end
          REQ_READ: begin
            state_next = sts.pos_bad ? S_DONE : S_READ_WAIT;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_UP_CHK: begin
        state_next = sts.at_target ? S_DONE : S_UP_MOVE;
      end
      S_UP_MOVE: state_next = S_UP_CHK;
      S_DN_CHK: begin
        state_next = sts.at_last ? S_DONE : S_DN_MOVE;
      end
      S_DN_MOVE:   state_next = S_DN_CHK;
      S_READ_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (!sts.res_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RA_POS;
    cmd.wr_sel  = WA_CUR;
    cmd.st_code = ST_OK;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DECODE: begin
        unique case (sts.op) inside
          REQ_INS_HEAD, REQ_INS_TAIL: begin
            if (sts.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.cur_held = 1'b1;
            end
          end
          REQ_INS_AFTER: begin
            if (sts.pos_bad) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_BAD_POS;
            end else if (sts.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.cur_held = 1'b1;
            end
          end
          REQ_DEL_HEAD: begin
            if (sts.empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_EMPTY;
            end else begin
              cmd.cur_zero = 1'b1;
            end
          end
          REQ_DEL_TAIL: begin
            cmd.st_set = 1'b1;
            if (sts.empty) begin
              cmd.st_code = ST_EMPTY;
            end else begin
              cmd.held_dec = 1'b1;
            end
          end
          REQ_READ: begin
            cmd.st_set = 1'b1;
            if (sts.pos_bad) begin
              cmd.st_code = ST_BAD_POS;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          REQ_CLEAR: begin
            cmd.st_set   = 1'b1;
            cmd.held_clr = 1'b1;
          end
          default: cmd.st_set = 1'b1;
        endcase
      end
      S_UP_CHK: begin
        if (sts.at_target) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WA_TARGET;
          cmd.held_inc = 1'b1;
          cmd.st_set   = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_BELOW;
        end
      end
      S_UP_MOVE: begin
        cmd.wr_en   = 1'b1;
        cmd.cur_dec = 1'b1;
      end
      S_DN_CHK: begin
        if (sts.at_last) begin
          cmd.held_dec = 1'b1;
          cmd.st_set   = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_ABOVE;
        end
      end
      S_DN_MOVE: begin
        cmd.wr_en   = 1'b1;
        cmd.cur_inc = 1'b1;
      end
      S_READ_WAIT: begin
      end
      S_DONE: begin
        cmd.res_load = !sts.res_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  a_held_one_op : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.held_inc, cmd.held_dec, cmd.held_clr}))
    else $error("conflicting count updates");

  a_cur_one_op : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cur_held, cmd.cur_zero, cmd.cur_dec, cmd.cur_inc}))
    else $error("conflicting cursor updates");

  a_latch_decode : assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_DECODE))
    else $error("accepted request not decoded");

endmodule

// File: sv/bounded_list_engine.sv
// To result valid: delete tail, clear and refused requests pass decode and done, read
// also read wait; an insert alternates up check and up move per entry moved up, delete
// head down check and down move per entry moved down. Each moved entry costs one store
// read and one store write. One request is in work at a time, the next taken in the
// cycle after its result is registered; an untaken result word stalls input.
// Reset (rst, synchronous) empties the list and the result stage; store contents
// are not cleared and need no clearing pass.
module bounded_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_value[31:0], entry_count[38:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import ble_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [VAL_W-1:0] read_value;
  logic [CNT_OUT_W-1:0]    entry_count;

  // controller: one state per step of a request, stalls in the done state
  // until the result word has a free slot
  ble_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: entry store, count, cursor and the registered result word
  ble_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .req_in      (s_axis_tuser),
    .value_in    (s_axis_tdata[31:0]),
    .pos_in      (s_axis_tdata[37:32]),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_axis_tready),
    .res_valid   (m_axis_tvalid),
    .status      (m_axis_tuser),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  // pack the result word, pad the top bit with zero
  assign m_axis_tdata = {1'b0, entry_count, read_value};

endmodule
